/* rtl/core/bti_pkg.sv */
package bti_pkg;

  localparam int unsigned DefMaxRows     = 16;
  localparam int unsigned DefMaxColumns  = 16;
  localparam int unsigned DefFracBits    = 16;
  localparam int unsigned CoordW         = 32;
  localparam int unsigned ValueW         = 31;
  localparam int unsigned CountW         = 5;
  localparam int unsigned IndexW         = 4;
  localparam int unsigned CfgIdxW        = 1;

  typedef enum logic [1:0] {
    ACT_ROW_POINT = 2'd0,
    ACT_COL_POINT = 2'd1,
    ACT_VALUE     = 2'd2,
    ACT_QUERY     = 2'd3
  } action_e;

  localparam logic [CfgIdxW-1:0] CFG_ROW_POINTS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COL_POINTS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_GRID,
    ST_CLAMP,
    ST_DIVIDE,
    ST_FETCH,
    ST_MUL_A,
    ST_MUL_B,
    ST_ROUND,
    ST_OUTPUT
  } state_e;

endpackage

/* rtl/core/bilinear_table_interpolator_top.sv */
// Channel   | Direction | Fields, low bits first
// s_axis    | in        | tdata: action, row_index, column_index, write_value, deployment, mach
// m_axis    | out       | tdata: drag_area
// cfg       | in        | cfg_we_i / cfg_index_i / cfg_data_i, one write per cycle
// A load transfer keeps ready high for the next item.
// A query keeps ready low until its result enters the output register: per axis one clamp,
// a walk over the grid points, one grid read and a restoring divide, then four table
// fetches, three blends on one 31x17 multiplier and one output step.
// Reset clears control state only; grids and table are undefined until written.
// The result register holds while m_axis_tready is low; a finished query waits for it.
module bilinear_table_interpolator_top
  import bti_pkg::*;
#(
  parameter int unsigned MaxRows    = DefMaxRows,
  parameter int unsigned MaxColumns = DefMaxColumns,
  parameter int unsigned FracBits   = DefFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // action[1:0], row_index[5:2], column_index[9:6], write_value[41:10],
  // deployment[73:42], mach[105:74], zero fill to 112
  input  logic [111:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // drag_area[30:0], zero fill to 32
  output logic [31:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CountW-1:0]   cfg_data_i
);

  localparam int unsigned RowW   = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned ColW   = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int unsigned RcntW  = $clog2(MaxRows + 1);
  localparam int unsigned CcntW  = $clog2(MaxColumns + 1);
  localparam int unsigned QW     = FracBits + 1;
  localparam int unsigned DivCntW = $clog2(QW + 1);
  localparam int unsigned DivW   = CoordW + 1;
  localparam int unsigned TableDepth = 1 << (RowW + ColW);
  localparam logic [QW-1:0] FracOne = QW'(1) << FracBits;

  // Input field split.
  action_e             in_action;
  logic [IndexW-1:0]   in_row;
  logic [IndexW-1:0]   in_col;
  logic signed [31:0]  in_wv;
  logic signed [31:0]  in_dep;
  logic signed [31:0]  in_mach;
  assign in_action = action_e'(s_axis_tdata[1:0]);
  assign in_row    = s_axis_tdata[5:2];
  assign in_col    = s_axis_tdata[9:6];
  assign in_wv     = s_axis_tdata[41:10];
  assign in_dep    = s_axis_tdata[73:42];
  assign in_mach   = s_axis_tdata[105:74];

  // Configuration registers.
  logic [CountW-1:0] row_pts_q, col_pts_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pts_q <= CountW'(2);
      col_pts_q <= CountW'(2);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROW_POINTS) row_pts_q <= cfg_data_i;
      if (cfg_index_i == CFG_COL_POINTS) col_pts_q <= cfg_data_i;
    end
  end

  logic [RcntW-1:0] nr;
  logic [CcntW-1:0] nc;
  always_comb begin
    if (row_pts_q < CountW'(2)) nr = RcntW'(2);
    else if (32'(row_pts_q) > MaxRows) nr = RcntW'(MaxRows);
    else nr = RcntW'(row_pts_q);
    if (col_pts_q < CountW'(2)) nc = CcntW'(2);
    else if (32'(col_pts_q) > MaxColumns) nc = CcntW'(MaxColumns);
    else nc = CcntW'(col_pts_q);
  end

  // Storage.
  logic signed [31:0] row_grid_q [MaxRows];
  logic signed [31:0] col_grid_q [MaxColumns];
  logic [ValueW-1:0]  table_mem  [TableDepth];

  state_e state_q, state_d;
  logic              axis_q;       // 0 row axis, 1 column axis
  logic [RcntW-1:0]  rscan_q;      // row walk index
  logic [CcntW-1:0]  cscan_q;
  logic [RowW-1:0]   r_q;
  logic [ColW-1:0]   c_q;
  logic signed [31:0] x_q, dep_q, mach_q;
  logic signed [31:0] g0_q, g1_q, gfirst_q, glast_q;
  logic [QW-1:0]     fr_q, fc_q, f_q;
  logic [DivW-1:0]   rem_q;
  logic [DivW-1:0]   den_q;
  logic [QW-1:0]     quo_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [1:0]        blend_q;      // which of three blends
  logic [1:0]        fetch_q;      // table fetch slot
  logic [ValueW-1:0] v_q [4];
  logic [ValueW-1:0] rd_q;
  logic [ValueW-1:0] lo_q, hi_q, bla_q, blb_q;
  logic [63:0]       acc_q;
  logic [63:0]       prod;
  logic [ValueW-1:0] res_q;
  logic              mvalid_q;

  logic in_xfer;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Table memory: one write port and one registered read port.
  logic [RowW+ColW-1:0] rd_addr;
  always_comb begin
    case (fetch_q)
      2'd0: rd_addr = {r_q, c_q};
      2'd1: rd_addr = {RowW'(r_q + 1'b1), c_q};
      2'd2: rd_addr = {r_q, ColW'(c_q + 1'b1)};
      default: rd_addr = {RowW'(r_q + 1'b1), ColW'(c_q + 1'b1)};
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_action == ACT_VALUE && 32'(in_row) < MaxRows &&
        32'(in_col) < MaxColumns) begin
      table_mem[{RowW'(in_row), ColW'(in_col)}] <= in_wv[31] ? '0 : in_wv[ValueW-1:0];
    end
    rd_q <= table_mem[rd_addr];
  end

  // Grid writes.
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_action == ACT_ROW_POINT && 32'(in_row) < MaxRows)
      row_grid_q[RowW'(in_row)] <= in_wv;
    if (in_xfer && in_action == ACT_COL_POINT && 32'(in_col) < MaxColumns)
      col_grid_q[ColW'(in_col)] <= in_wv;
  end

  // Shared multiplier: value times weight.
  logic [QW-1:0] mul_w;
  logic [ValueW-1:0] mul_v;
  assign mul_v = (state_q == ST_MUL_A) ? bla_q : blb_q;
  assign mul_w = (state_q == ST_MUL_A) ? (FracOne - f_q) : f_q;
  assign prod  = 64'(mul_v) * 64'(mul_w);

  // Search-step values.
  logic signed [31:0] gcur;
  logic last_i;
  assign gcur = axis_q ? col_grid_q[ColW'(cscan_q)] : row_grid_q[RowW'(rscan_q)];
  assign last_i = axis_q ? (cscan_q == CcntW'(nc - CcntW'(2)))
                         : (rscan_q == RcntW'(nr - RcntW'(2)));

  // Divider step: restoring, one quotient bit per cycle, zeros shifted in.
  logic [DivW-1:0] trial;
  assign trial = {rem_q[DivW-2:0], 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer && in_action == ACT_QUERY) state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_SEARCH;
      ST_SEARCH: if (last_i) state_d = ST_GRID;
      ST_GRID:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (dcnt_q == '0) state_d = axis_q ? ST_FETCH : ST_CLAMP;
      ST_FETCH:  if (fetch_q == 2'd3) state_d = ST_MUL_A;
      ST_MUL_A:  state_d = ST_MUL_B;
      ST_MUL_B:  state_d = ST_ROUND;
      ST_ROUND:  state_d = (blend_q == 2'd2) ? ST_OUTPUT : ST_MUL_A;
      ST_OUTPUT: if (!mvalid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Datapath sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 1'b0;
      fetch_q <= '0;
      blend_q <= '0;
      dcnt_q <= '0;
      rscan_q <= '0;
      cscan_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          axis_q <= 1'b0;
          fetch_q <= '0;
          blend_q <= '0;
        end
        ST_CLAMP: begin
          rscan_q <= '0;
          cscan_q <= '0;
        end
        ST_SEARCH: begin
          if (!last_i) begin
            if (axis_q) cscan_q <= cscan_q + 1'b1;
            else rscan_q <= rscan_q + 1'b1;
          end
        end
        ST_GRID: dcnt_q <= DivCntW'(QW);
        ST_DIVIDE: begin
          if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
          else axis_q <= 1'b1;
        end
        ST_FETCH: fetch_q <= fetch_q + 1'b1;
        ST_ROUND: blend_q <= blend_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Interval offsets at full precision, so wide grid spans keep their sign.
  logic signed [CoordW:0] diff_s, width_s;
  logic [CoordW-1:0] diff_w, width_w;
  assign diff_s  = {x_q[CoordW-1], x_q} - {g0_q[CoordW-1], g0_q};
  assign width_s = {g1_q[CoordW-1], g1_q} - {g0_q[CoordW-1], g0_q};
  assign diff_w  = diff_s[CoordW-1:0];
  assign width_w = width_s[CoordW-1:0];

  // Fraction of the current axis, saturated to the ends of the interval.
  logic [QW-1:0] axis_frac;
  always_comb begin
    if (width_s <= 0 || diff_s <= 0) axis_frac = '0;
    else if (diff_s >= width_s) axis_frac = FracOne;
    else axis_frac = quo_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_xfer) begin
        dep_q <= in_dep;
        mach_q <= in_mach;
      end
      ST_CLAMP: begin
        // Load the coordinate of the current axis and its grid ends for the clamp.
        if (axis_q) begin
          gfirst_q <= col_grid_q[0];
          glast_q <= col_grid_q[ColW'(nc - 1'b1)];
          x_q <= mach_q;
        end else begin
          gfirst_q <= row_grid_q[0];
          glast_q <= row_grid_q[RowW'(nr - 1'b1)];
          x_q <= dep_q;
        end
        r_q <= axis_q ? r_q : '0;
        c_q <= '0;
      end
      ST_SEARCH: begin
        if (rscan_q == '0 && cscan_q == '0) begin
          if (x_q < gfirst_q) x_q <= gfirst_q;
          else if (x_q > glast_q) x_q <= glast_q;
        end
        if (gcur <= ((x_q < gfirst_q) ? gfirst_q : (x_q > glast_q) ? glast_q : x_q)) begin
          if (axis_q) c_q <= ColW'(cscan_q);
          else r_q <= RowW'(rscan_q);
        end
      end
      ST_GRID: begin
        g0_q <= axis_q ? col_grid_q[c_q] : row_grid_q[r_q];
        g1_q <= axis_q ? col_grid_q[ColW'(c_q + 1'b1)] : row_grid_q[RowW'(r_q + 1'b1)];
      end
      ST_DIVIDE: begin
        if (dcnt_q == DivCntW'(QW)) begin
          // diff is below width whenever the quotient is used, so the integer steps
          // of diff << FracBits yield nothing and leave diff as the remainder.
          rem_q <= DivW'(diff_w);
          den_q <= DivW'(width_w);
          quo_q <= '0;
        end else if (trial >= den_q) begin
          rem_q <= trial - den_q;
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      ST_FETCH: begin
        // Read data arrives in the cycle after its address.
        if (fetch_q != 2'd0) v_q[fetch_q - 1'b1] <= rd_q;
        // The first blend mixes the two row neighbors of the lower column.
        if (fetch_q == 2'd3) begin
          bla_q <= v_q[0];
          blb_q <= v_q[1];
        end
      end
      ST_MUL_A: begin
        if (blend_q == 2'd0) v_q[3] <= rd_q;
        acc_q <= prod;
      end
      ST_MUL_B: acc_q <= acc_q + prod + 64'(FracOne >> 1);
      ST_ROUND: begin
        case (blend_q)
          2'd0: begin
            lo_q <= ValueW'(acc_q >> FracBits);
            bla_q <= v_q[2];
            blb_q <= v_q[3];
          end
          2'd1: begin
            hi_q <= ValueW'(acc_q >> FracBits);
            bla_q <= lo_q;
            blb_q <= ValueW'(acc_q >> FracBits);
            f_q <= fc_q;
          end
          default: res_q <= ValueW'(acc_q >> FracBits);
        endcase
      end
      default: ;
    endcase
    // Hold the per-axis fraction once the divider finishes.
    if (state_q == ST_DIVIDE && dcnt_q == '0) begin
      if (!axis_q) fr_q <= axis_frac;
      else fc_q <= axis_frac;
    end
    if (state_q == ST_FETCH && fetch_q == 2'd0) f_q <= fr_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mvalid_q <= 1'b0;
    else if (state_q == ST_OUTPUT && (!mvalid_q || m_axis_tready)) mvalid_q <= 1'b1;
    else if (m_axis_tready) mvalid_q <= 1'b0;
  end

  logic [ValueW-1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUTPUT && (!mvalid_q || m_axis_tready)) out_q <= res_q;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  logic unused_hi;
  assign unused_hi = ^{hi_q, s_axis_tdata[111:106]};

endmodule

/* rtl/core/bti_checker.sv */
module bti_checker
  import bti_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [111:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // The spare top bit of the result is always zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("result pad bit set");

  // An accepted query drops ready on the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == ACT_QUERY |=> !s_axis_tready)
    else $error("query did not occupy the block");

  // A load item causes no result on the following cycle.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != ACT_QUERY && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("load produced a result");

endmodule

bind bilinear_table_interpolator_top bti_checker u_bti_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
